>>> rtl/shah_pkg.sv
// Shared types, codes, constants and round functions of the SHA hash engine.
`default_nettype none

package shah_pkg;

	// hash_mode register codes
	localparam logic [1:0] MODE_SHA1   = 2'd0;
	localparam logic [1:0] MODE_SHA256 = 2'd1;
	localparam logic [1:0] MODE_SHA384 = 2'd2;
	localparam logic [1:0] MODE_SHA512 = 2'd3;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_PAD80,
		ST_PADZERO,
		ST_PADLEN,
		ST_CINIT,
		ST_CROUND,
		ST_CFINAL,
		ST_DIGEST
	} state_t;

	// source of the byte written into the block buffer
	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_PAD80,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      load_word;
		logic      write_byte;
		byte_sel_t byte_sel;
		logic      init_vars;
		logic      round_en;
		logic [6:0] round_idx;
		logic      finish_block;
		logic      start_run;
		logic      out_load;
		logic [3:0] out_idx;
		logic      out_last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       fill_full;
		logic       fill_at_len;
		logic       pad_extra;
		logic       out_free;
	} dp_stat_t;

	// round constants, SHA-256 takes the upper half
	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k;
		case (t)
			7'd0:  k = 64'h428A2F98D728AE22; 7'd1:  k = 64'h7137449123EF65CD;
			7'd2:  k = 64'hB5C0FBCFEC4D3B2F; 7'd3:  k = 64'hE9B5DBA58189DBBC;
			7'd4:  k = 64'h3956C25BF348B538; 7'd5:  k = 64'h59F111F1B605D019;
			7'd6:  k = 64'h923F82A4AF194F9B; 7'd7:  k = 64'hAB1C5ED5DA6D8118;
			7'd8:  k = 64'hD807AA98A3030242; 7'd9:  k = 64'h12835B0145706FBE;
			7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
			7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
			7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
			7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
			7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
			7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
			7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
			7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
			7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
			7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
			7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
			7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
			7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
			7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
			7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
			7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
			7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
			7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
			7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
			7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
			7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
			7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
			7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
			7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
			7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
			7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
			7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
			7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
			7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
			7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
			7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
			7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
			7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
			7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
			7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

	// initial chain word i of a mode
	function automatic logic [63:0] init_hash(input logic [1:0] mode, input logic [2:0] i);
		logic [63:0] s512;
		logic [63:0] s384;
		logic [31:0] s1;
		case (i)
			3'd0: s512 = 64'h6A09E667F3BCC908; 3'd1: s512 = 64'hBB67AE8584CAA73B;
			3'd2: s512 = 64'h3C6EF372FE94F82B; 3'd3: s512 = 64'hA54FF53A5F1D36F1;
			3'd4: s512 = 64'h510E527FADE682D1; 3'd5: s512 = 64'h9B05688C2B3E6C1F;
			3'd6: s512 = 64'h1F83D9ABFB41BD6B; default: s512 = 64'h5BE0CD19137E2179;
		endcase
		case (i)
			3'd0: s384 = 64'hCBBB9D5DC1059ED8; 3'd1: s384 = 64'h629A292A367CD507;
			3'd2: s384 = 64'h9159015A3070DD17; 3'd3: s384 = 64'h152FECD8F70E5939;
			3'd4: s384 = 64'h67332667FFC00B31; 3'd5: s384 = 64'h8EB44A8768581511;
			3'd6: s384 = 64'hDB0C2E0D64F98FA7; default: s384 = 64'h47B5481DBEFA4FA4;
		endcase
		case (i)
			3'd0: s1 = 32'h67452301; 3'd1: s1 = 32'hEFCDAB89;
			3'd2: s1 = 32'h98BADCFE; 3'd3: s1 = 32'h10325476;
			3'd4: s1 = 32'hC3D2E1F0; default: s1 = 32'h0;
		endcase
		case (mode)
			MODE_SHA1:   return {32'h0, s1};
			MODE_SHA256: return {32'h0, s512[63:32]};
			MODE_SHA384: return s384;
			default:     return s512;
		endcase
	endfunction

	function automatic logic [31:0] rr32(input logic [31:0] x, input int unsigned s);
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [63:0] rr64(input logic [63:0] x, input int unsigned s);
		return (x >> s) | (x << (64 - s));
	endfunction

endpackage

`default_nettype wire

>>> rtl/shah_dp.sv
// Datapath: block buffer and schedule window, working variables, chain value, digest output.
`default_nettype none

module shah_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic [63:0]       message_word,
	input  wire shah_pkg::dp_cmd_t cmd,
	output shah_pkg::dp_stat_t     stat,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [31:0]            digest_word,
	output logic                   digest_last
);
	import shah_pkg::*;

	logic [1:0]  mode_q;
	logic [6:0]  fill_q;
	logic [63:0] bit_count_q;
	logic [63:0] word_q;
	logic [63:0] buf_q [16];
	logic [63:0] vars_q [8];
	logic [63:0] chain_q [8];
	logic        out_valid_q;
	logic [31:0] digest_word_q;
	logic        digest_last_q;

	logic        wide;
	logic [7:0]  wr_byte;
	logic [2:0]  len_sel;
	logic [3:0]  wr_idx;
	logic [5:0]  wr_sh;
	logic [63:0] new_w;
	logic [63:0] nv [8];
	logic [63:0] chain_rd;

	assign wide = mode_q[1];

	// status to controller
	always_comb begin
		stat.mode        = mode_q;
		stat.fill_full   = fill_q == (wide ? 7'd127 : 7'd63);
		stat.fill_at_len = fill_q == (wide ? 7'd120 : 7'd56);
		stat.pad_extra   = wide ? (fill_q >= 7'd112) : (fill_q >= 7'd56);
		stat.out_free    = !out_valid_q || !out_stall;
	end

	// byte source and its place in the buffer
	always_comb begin
		len_sel = ~fill_q[2:0];
		case (cmd.byte_sel)
			BSEL_DATA:  wr_byte = word_q[63:56];
			BSEL_PAD80: wr_byte = 8'h80;
			BSEL_ZERO:  wr_byte = 8'h00;
			default:    wr_byte = 8'(bit_count_q >> {len_sel, 3'b000});
		endcase
		if (wide) begin
			wr_idx = fill_q[6:3];
			wr_sh  = {~fill_q[2:0], 3'b000};
		end else begin
			wr_idx = fill_q[5:2];
			wr_sh  = {1'b0, ~fill_q[1:0], 3'b000};
		end
	end

	// next schedule word
	always_comb begin
		logic [31:0] x32;
		x32 = 32'h0;
		new_w = 64'h0;
		case (mode_q)
			MODE_SHA1: begin
				x32 = buf_q[13][31:0] ^ buf_q[8][31:0] ^ buf_q[2][31:0] ^ buf_q[0][31:0];
				new_w = {32'h0, x32[30:0], x32[31]};
			end
			MODE_SHA256: begin
				new_w = {32'h0,
					(rr32(buf_q[14][31:0], 17) ^ rr32(buf_q[14][31:0], 19)
						^ (buf_q[14][31:0] >> 10))
					+ buf_q[9][31:0]
					+ (rr32(buf_q[1][31:0], 7) ^ rr32(buf_q[1][31:0], 18)
						^ (buf_q[1][31:0] >> 3))
					+ buf_q[0][31:0]};
			end
			default: begin
				new_w = (rr64(buf_q[14], 19) ^ rr64(buf_q[14], 61) ^ (buf_q[14] >> 6))
					+ buf_q[9]
					+ (rr64(buf_q[1], 1) ^ rr64(buf_q[1], 8) ^ (buf_q[1] >> 7))
					+ buf_q[0];
			end
		endcase
	end

	// one compression round
	always_comb begin
		logic [63:0] k;
		logic [31:0] f1;
		logic [31:0] k1;
		logic [31:0] t1a;
		logic [31:0] t2a;
		logic [63:0] t1b;
		logic [63:0] t2b;
		k = round_k(cmd.round_idx);
		if (cmd.round_idx < 7'd20) begin
			f1 = (vars_q[1][31:0] & vars_q[2][31:0]) ^ (~vars_q[1][31:0] & vars_q[3][31:0]);
			k1 = 32'h5a827999;
		end else if (cmd.round_idx < 7'd40) begin
			f1 = vars_q[1][31:0] ^ vars_q[2][31:0] ^ vars_q[3][31:0];
			k1 = 32'h6ed9eba1;
		end else if (cmd.round_idx < 7'd60) begin
			f1 = (vars_q[1][31:0] & vars_q[2][31:0]) ^ (vars_q[1][31:0] & vars_q[3][31:0])
				^ (vars_q[2][31:0] & vars_q[3][31:0]);
			k1 = 32'h8f1bbcdc;
		end else begin
			f1 = vars_q[1][31:0] ^ vars_q[2][31:0] ^ vars_q[3][31:0];
			k1 = 32'hca62c1d6;
		end
		t1a = vars_q[7][31:0]
			+ (rr32(vars_q[4][31:0], 6) ^ rr32(vars_q[4][31:0], 11) ^ rr32(vars_q[4][31:0], 25))
			+ ((vars_q[4][31:0] & vars_q[5][31:0]) ^ (~vars_q[4][31:0] & vars_q[6][31:0]))
			+ k[63:32] + buf_q[0][31:0];
		t2a = (rr32(vars_q[0][31:0], 2) ^ rr32(vars_q[0][31:0], 13) ^ rr32(vars_q[0][31:0], 22))
			+ ((vars_q[0][31:0] & vars_q[1][31:0]) ^ (vars_q[0][31:0] & vars_q[2][31:0])
				^ (vars_q[1][31:0] & vars_q[2][31:0]));
		t1b = vars_q[7]
			+ (rr64(vars_q[4], 14) ^ rr64(vars_q[4], 18) ^ rr64(vars_q[4], 41))
			+ ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
			+ k + buf_q[0];
		t2b = (rr64(vars_q[0], 28) ^ rr64(vars_q[0], 34) ^ rr64(vars_q[0], 39))
			+ ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
		case (mode_q)
			MODE_SHA1: begin
				nv[0] = {32'h0, {vars_q[0][26:0], vars_q[0][31:27]} + f1
					+ vars_q[4][31:0] + buf_q[0][31:0] + k1};
				nv[1] = {32'h0, vars_q[0][31:0]};
				nv[2] = {32'h0, vars_q[1][1:0], vars_q[1][31:2]};
				nv[3] = {32'h0, vars_q[2][31:0]};
				nv[4] = {32'h0, vars_q[3][31:0]};
				nv[5] = vars_q[5];
				nv[6] = vars_q[6];
				nv[7] = vars_q[7];
			end
			MODE_SHA256: begin
				nv[0] = {32'h0, t1a + t2a};
				nv[1] = {32'h0, vars_q[0][31:0]};
				nv[2] = {32'h0, vars_q[1][31:0]};
				nv[3] = {32'h0, vars_q[2][31:0]};
				nv[4] = {32'h0, vars_q[3][31:0] + t1a};
				nv[5] = {32'h0, vars_q[4][31:0]};
				nv[6] = {32'h0, vars_q[5][31:0]};
				nv[7] = {32'h0, vars_q[6][31:0]};
			end
			default: begin
				nv[0] = t1b + t2b;
				nv[1] = vars_q[0];
				nv[2] = vars_q[1];
				nv[3] = vars_q[2];
				nv[4] = vars_q[3] + t1b;
				nv[5] = vars_q[4];
				nv[6] = vars_q[5];
				nv[7] = vars_q[6];
			end
		endcase
	end

	// chain entry of the digest word, 64-bit modes give the high half first
	always_comb begin
		chain_rd = chain_q[wide ? cmd.out_idx[3:1] : cmd.out_idx[2:0]];
	end

	// mode, fill and bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SHA256;
			fill_q      <= 7'd0;
			bit_count_q <= 64'd0;
		end else if (cfg_we) begin
			mode_q      <= cfg_wdata;
			fill_q      <= 7'd0;
			bit_count_q <= 64'd0;
		end else if (cmd.start_run || cmd.finish_block) begin
			fill_q <= 7'd0;
			if (cmd.start_run)
				bit_count_q <= 64'd0;
		end else if (cmd.write_byte) begin
			fill_q <= fill_q + 7'd1;
			if (cmd.byte_sel == BSEL_DATA)
				bit_count_q <= bit_count_q + 64'd8;
		end
	end

	// chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				chain_q[i] <= init_hash(MODE_SHA256, 3'(i));
		end else if (cfg_we) begin
			for (int i = 0; i < 8; i++)
				chain_q[i] <= init_hash(cfg_wdata, 3'(i));
		end else if (cmd.start_run) begin
			for (int i = 0; i < 8; i++)
				chain_q[i] <= init_hash(mode_q, 3'(i));
		end else if (cmd.finish_block) begin
			for (int i = 0; i < 8; i++) begin
				if (wide)
					chain_q[i] <= chain_q[i] + vars_q[i];
				else
					chain_q[i] <= {32'h0, chain_q[i][31:0] + vars_q[i][31:0]};
			end
		end
	end

	// input word, buffer and working variables
	always_ff @(posedge clk) begin
		if (cmd.load_word)
			word_q <= message_word;
		else if (cmd.write_byte && cmd.byte_sel == BSEL_DATA)
			word_q <= {word_q[55:0], 8'h00};
		if (cmd.write_byte) begin
			buf_q[wr_idx] <= (buf_q[wr_idx] & ~(64'hFF << wr_sh)) | (64'(wr_byte) << wr_sh);
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++)
				buf_q[i] <= buf_q[i + 1];
			buf_q[15] <= new_w;
		end
		if (cmd.init_vars) begin
			for (int i = 0; i < 8; i++)
				vars_q[i] <= chain_q[i];
		end else if (cmd.round_en) begin
			for (int i = 0; i < 8; i++)
				vars_q[i] <= nv[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			digest_word_q <= (wide && !cmd.out_idx[0]) ? chain_rd[63:32] : chain_rd[31:0];
			digest_last_q <= cmd.out_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_word_q;
	assign digest_last = digest_last_q;

endmodule

`default_nettype wire

>>> rtl/shah_ctrl.sv
// Controller: sequences byte absorb, padding, compression rounds and digest transfers.
`default_nettype none

module shah_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         valid_bytes,
	input  wire logic               message_last,
	input  wire shah_pkg::dp_stat_t stat,
	output shah_pkg::dp_cmd_t       cmd
);
	import shah_pkg::*;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [3:0] left_q, left_d;
	logic       last_q, last_d;
	logic       extra_q, extra_d;
	logic [6:0] round_q, round_d;
	logic [3:0] idx_q, idx_d;
	logic [6:0] round_end;
	logic [3:0] idx_end;

	assign in_stall = state_q != ST_IDLE;

	// rounds per block and digest length by mode
	always_comb begin
		round_end = (stat.mode == MODE_SHA256) ? 7'd63 : 7'd79;
		case (stat.mode)
			MODE_SHA1:   idx_end = 4'd4;
			MODE_SHA256: idx_end = 4'd7;
			MODE_SHA384: idx_end = 4'd11;
			default:     idx_end = 4'd15;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			left_q  <= 4'd0;
			last_q  <= 1'b0;
			extra_q <= 1'b0;
			round_q <= 7'd0;
			idx_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			left_q  <= left_d;
			last_q  <= last_d;
			extra_q <= extra_d;
			round_q <= round_d;
			idx_q   <= idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		left_d  = left_q;
		last_d  = last_q;
		extra_d = extra_q;
		round_d = round_q;
		idx_d   = idx_q;
		cmd           = '0;
		cmd.byte_sel  = BSEL_DATA;
		cmd.round_idx = round_q;
		cmd.out_idx   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_word = 1'b1;
					left_d  = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
					last_d  = message_last;
					state_d = ST_ABSORB;
				end
			end
			ST_ABSORB: begin
				if (left_q == 4'd0) begin
					state_d = last_q ? ST_PAD80 : ST_IDLE;
				end else begin
					cmd.write_byte = 1'b1;
					left_d = left_q - 4'd1;
					if (stat.fill_full) begin
						ret_d   = ST_ABSORB;
						state_d = ST_CINIT;
					end
				end
			end
			ST_PAD80: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel   = BSEL_PAD80;
				if (stat.fill_full) begin
					extra_d = 1'b0;
					ret_d   = ST_PADZERO;
					state_d = ST_CINIT;
				end else begin
					extra_d = stat.pad_extra;
					state_d = ST_PADZERO;
				end
			end
			ST_PADZERO: begin
				if (stat.fill_at_len && !extra_q) begin
					state_d = ST_PADLEN;
				end else begin
					cmd.write_byte = 1'b1;
					cmd.byte_sel   = BSEL_ZERO;
					if (stat.fill_full) begin
						extra_d = 1'b0;
						ret_d   = ST_PADZERO;
						state_d = ST_CINIT;
					end
				end
			end
			ST_PADLEN: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel   = BSEL_LEN;
				if (stat.fill_full) begin
					ret_d   = ST_DIGEST;
					state_d = ST_CINIT;
				end
			end
			ST_CINIT: begin
				cmd.init_vars = 1'b1;
				round_d = 7'd0;
				state_d = ST_CROUND;
			end
			ST_CROUND: begin
				cmd.round_en = 1'b1;
				round_d = round_q + 7'd1;
				if (round_q == round_end)
					state_d = ST_CFINAL;
			end
			ST_CFINAL: begin
				cmd.finish_block = 1'b1;
				idx_d   = 4'd0;
				state_d = ret_q;
			end
			ST_DIGEST: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = idx_q == idx_end;
					idx_d = idx_q + 4'd1;
					if (idx_q == idx_end) begin
						cmd.start_run = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CROUND |-> round_q <= round_end)
		else $error("round counter past end of block");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGEST |-> idx_q <= idx_end)
		else $error("digest index past end");
	a_extra_scope: assert property (@(posedge clk) disable iff (!arst_n)
		extra_q |-> (state_q == ST_PADZERO || state_q == ST_CINIT
			|| state_q == ST_CROUND || state_q == ST_CFINAL))
		else $error("padding extra-block flag outside padding");
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 4'd8)
		else $error("byte count above eight");

endmodule

`default_nettype wire

>>> rtl/multi_mode_sha_hash_engine.sv
// Top level of the SHA-1/256/384/512 hash engine: controller plus datapath.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   message | in_valid, in_stall, message_word,         | in
//           | valid_bytes, message_last                 |
//   digest  | out_valid, out_stall, digest_word,        | out
//           | digest_last                               |
//   config  | cfg_we, cfg_wdata (hash_mode)             | in
//
// Bytes of a word go into the block buffer one per cycle, paused while a full block
// is compressed; the round unit compresses a block at one round per cycle. After the
// last word the engine writes the padding bytes and the length field, runs the extra
// compressions, and transfers the digest words. One message word is in work at a time.
// Reset selects SHA-256; a hash_mode write restarts the run. A stalled digest
// transfer holds the engine in the digest phase.
`default_nettype none

module multi_mode_sha_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] message_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        message_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic             digest_last
);
	import shah_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	shah_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.valid_bytes  (valid_bytes),
		.message_last (message_last),
		.stat         (stat),
		.cmd          (cmd)
	);

	// storage and round logic
	shah_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.message_word (message_word),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.digest_word  (digest_word),
		.digest_last  (digest_last)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_multi_mode_sha_hash_engine.sv
// Self-checking testbench of the multi-mode SHA hash engine with its own digest predictor.
`default_nettype none

module tb_multi_mode_sha_hash_engine;
	import shah_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 140;
	localparam logic [2:0] KEEP_MODE = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] message_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        message_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic        digest_last;

	multi_mode_sha_hash_engine dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .message_word(message_word),
		.valid_bytes(valid_bytes), .message_last(message_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .digest_last(digest_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one expected digest word transfer
	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_xfer_t;

	digest_xfer_t digest_q[$];
	int  fail_count = 0;
	int  cycle_count = 0;
	bit  quiet = 1'b0;
	logic [31:0] first_digest;

	// predictor state
	logic [1:0]  sha_mode;
	logic [63:0] chain[8];
	logic [63:0] blk[16];
	logic [63:0] msg_bits;
	int unsigned blk_fill;

	localparam logic [63:0] KTAB[80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};
	localparam logic [31:0] IV_SHA1[5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [63:0] IV_SHA384[8] = '{
		64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
		64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
	};
	localparam logic [63:0] IV_SHA512[8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	function automatic logic [31:0] rotl32(logic [31:0] x, int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] rotr32(logic [31:0] x, int s);
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [63:0] rotr64(logic [63:0] x, int s);
		return (x >> s) | (x << (64 - s));
	endfunction

	function automatic logic [31:0] half_word(int i);
		return i[0] ? blk[i >> 1][31:0] : blk[i >> 1][63:32];
	endfunction

	// fresh run with the initial hash of the current mode
	function automatic void restart_hash();
		for (int i = 0; i < 8; i++) begin
			case (sha_mode)
				MODE_SHA1:   chain[i] = i < 5 ? {32'h0, IV_SHA1[i]} : 64'h0;
				MODE_SHA256: chain[i] = {32'h0, IV_SHA512[i][63:32]};
				MODE_SHA384: chain[i] = IV_SHA384[i];
				default:     chain[i] = IV_SHA512[i];
			endcase
		end
		msg_bits = '0;
		blk_fill = 0;
	endfunction

	// one compression of the buffered block into the chain value
	function automatic void compress_block();
		logic [31:0] w32[80];
		logic [31:0] v32[8];
		logic [63:0] w64[80];
		logic [63:0] v64[8];
		logic [31:0] f, k, t1, t2;
		logic [63:0] u1, u2;
		if (sha_mode == MODE_SHA1) begin
			for (int t = 0; t < 16; t++) w32[t] = half_word(t);
			for (int t = 16; t < 80; t++)
				w32[t] = rotl32(w32[t-3] ^ w32[t-8] ^ w32[t-14] ^ w32[t-16], 1);
			for (int i = 0; i < 5; i++) v32[i] = chain[i][31:0];
			for (int t = 0; t < 80; t++) begin
				if (t < 20) begin
					f = (v32[1] & v32[2]) ^ (~v32[1] & v32[3]); k = 32'h5a827999;
				end else if (t < 40) begin
					f = v32[1] ^ v32[2] ^ v32[3]; k = 32'h6ed9eba1;
				end else if (t < 60) begin
					f = (v32[1] & v32[2]) ^ (v32[1] & v32[3]) ^ (v32[2] & v32[3]);
					k = 32'h8f1bbcdc;
				end else begin
					f = v32[1] ^ v32[2] ^ v32[3]; k = 32'hca62c1d6;
				end
				t1 = rotl32(v32[0], 5) + f + v32[4] + w32[t] + k;
				v32[4] = v32[3]; v32[3] = v32[2]; v32[2] = rotl32(v32[1], 30);
				v32[1] = v32[0]; v32[0] = t1;
			end
			for (int i = 0; i < 5; i++) chain[i] = {32'h0, chain[i][31:0] + v32[i]};
		end else if (sha_mode == MODE_SHA256) begin
			for (int t = 0; t < 16; t++) w32[t] = half_word(t);
			for (int t = 16; t < 64; t++)
				w32[t] = (rotr32(w32[t-2], 17) ^ rotr32(w32[t-2], 19) ^ (w32[t-2] >> 10))
					+ w32[t-7]
					+ (rotr32(w32[t-15], 7) ^ rotr32(w32[t-15], 18) ^ (w32[t-15] >> 3))
					+ w32[t-16];
			for (int i = 0; i < 8; i++) v32[i] = chain[i][31:0];
			for (int t = 0; t < 64; t++) begin
				t1 = v32[7] + (rotr32(v32[4], 6) ^ rotr32(v32[4], 11) ^ rotr32(v32[4], 25))
					+ ((v32[4] & v32[5]) ^ (~v32[4] & v32[6])) + KTAB[t][63:32] + w32[t];
				t2 = (rotr32(v32[0], 2) ^ rotr32(v32[0], 13) ^ rotr32(v32[0], 22))
					+ ((v32[0] & v32[1]) ^ (v32[0] & v32[2]) ^ (v32[1] & v32[2]));
				v32[7] = v32[6]; v32[6] = v32[5]; v32[5] = v32[4]; v32[4] = v32[3] + t1;
				v32[3] = v32[2]; v32[2] = v32[1]; v32[1] = v32[0]; v32[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] = {32'h0, chain[i][31:0] + v32[i]};
		end else begin
			for (int t = 0; t < 16; t++) w64[t] = blk[t];
			for (int t = 16; t < 80; t++)
				w64[t] = (rotr64(w64[t-2], 19) ^ rotr64(w64[t-2], 61) ^ (w64[t-2] >> 6))
					+ w64[t-7]
					+ (rotr64(w64[t-15], 1) ^ rotr64(w64[t-15], 8) ^ (w64[t-15] >> 7))
					+ w64[t-16];
			for (int i = 0; i < 8; i++) v64[i] = chain[i];
			for (int t = 0; t < 80; t++) begin
				u1 = v64[7] + (rotr64(v64[4], 14) ^ rotr64(v64[4], 18) ^ rotr64(v64[4], 41))
					+ ((v64[4] & v64[5]) ^ (~v64[4] & v64[6])) + KTAB[t] + w64[t];
				u2 = (rotr64(v64[0], 28) ^ rotr64(v64[0], 34) ^ rotr64(v64[0], 39))
					+ ((v64[0] & v64[1]) ^ (v64[0] & v64[2]) ^ (v64[1] & v64[2]));
				v64[7] = v64[6]; v64[6] = v64[5]; v64[5] = v64[4]; v64[4] = v64[3] + u1;
				v64[3] = v64[2]; v64[2] = v64[1]; v64[1] = v64[0]; v64[0] = u1 + u2;
			end
			for (int i = 0; i < 8; i++) chain[i] = chain[i] + v64[i];
		end
	endfunction

	function automatic void put_byte(int unsigned pos, logic [7:0] b);
		blk[(pos >> 3) & 15][(7 - (pos & 7)) * 8 +: 8] = b;
	endfunction

	function automatic int unsigned block_size();
		return sha_mode >= MODE_SHA384 ? 128 : 64;
	endfunction

	// absorb one transfer; on the last word pad and queue the digest
	function automatic void hash_word(logic [63:0] word, logic [3:0] nbytes, logic last);
		int unsigned n, bb, lenb, cnt;
		digest_xfer_t d;
		digest_xfer_t outs[$];
		n = nbytes > 8 ? 8 : nbytes;
		bb = block_size();
		for (int i = 0; i < n; i++) begin
			put_byte(blk_fill, word[(7 - i) * 8 +: 8]);
			blk_fill++;
			msg_bits += 64'd8;
			if (blk_fill >= bb) begin
				compress_block();
				blk_fill = 0;
			end
		end
		if (!last) return;
		lenb = sha_mode >= MODE_SHA384 ? 16 : 8;
		put_byte(blk_fill, 8'h80);
		blk_fill++;
		if (blk_fill > bb - lenb) begin
			while (blk_fill < bb) begin
				put_byte(blk_fill, 8'h00);
				blk_fill++;
			end
			compress_block();
			blk_fill = 0;
		end
		while (blk_fill < bb - 8) begin
			put_byte(blk_fill, 8'h00);
			blk_fill++;
		end
		for (int i = 0; i < 8; i++) put_byte(bb - 8 + i, msg_bits[(7 - i) * 8 +: 8]);
		compress_block();
		if (sha_mode <= MODE_SHA256) begin
			cnt = sha_mode == MODE_SHA1 ? 5 : 8;
			for (int i = 0; i < cnt; i++) begin
				d.word = chain[i][31:0]; d.last = 1'b0; outs.push_back(d);
			end
		end else begin
			cnt = sha_mode == MODE_SHA384 ? 6 : 8;
			for (int i = 0; i < cnt; i++) begin
				d.word = chain[i][63:32]; d.last = 1'b0; outs.push_back(d);
				d.word = chain[i][31:0]; outs.push_back(d);
			end
		end
		outs[outs.size() - 1].last = 1'b1;
		first_digest = outs[0].word;
		foreach (outs[i]) digest_q.push_back(outs[i]);
		restart_hash();
	endfunction

	// one transfer on the message channel; entered and left at a falling edge
	task automatic send_word(logic [63:0] word, logic [3:0] nbytes, logic last);
		int gap;
		in_valid <= 1'b1;
		message_word <= word;
		valid_bytes <= nbytes;
		message_last <= last;
		do @(posedge clk); while (in_stall);
		hash_word(word, nbytes, last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// mode write once the engine has drained
	task automatic write_mode(logic [1:0] m);
		in_valid <= 1'b0;
		wait (digest_q.size() == 0);
		repeat (300) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		sha_mode = m;
		restart_hash();
	endtask

	// directed stimulus: mode write before the row, and the first digest word
	// where it is a well-known value
	typedef struct {
		logic [2:0]  mode;
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        known;
		logic [31:0] first;
	} stim_row_t;

	localparam logic [63:0] ABC = 64'h6162630000000000;

	stim_row_t stim_tab[] = '{
		'{KEEP_MODE, 64'h0, 4'd0, 1'b1, 1'b1, 32'he3b0c442},
		'{KEEP_MODE, ABC, 4'd3, 1'b1, 1'b1, 32'hba7816bf},
		'{KEEP_MODE, 64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b0, 1'b0, 32'h0},
		'{KEEP_MODE, 64'hDEADBEEF00000000, 4'd0, 1'b0, 1'b0, 32'h0},
		'{KEEP_MODE, 64'h0, 4'd8, 1'b1, 1'b0, 32'h0},
		'{KEEP_MODE, 64'hA5FFFFFFFFFFFFFF, 4'd1, 1'b0, 1'b0, 32'h0},
		'{KEEP_MODE, 64'h0123456789ABCDEF, 4'd5, 1'b0, 1'b0, 32'h0},
		'{KEEP_MODE, 64'hFEDCBA9876543210, 4'd0, 1'b1, 1'b0, 32'h0},
		'{3'(MODE_SHA1), 64'h0, 4'd0, 1'b1, 1'b1, 32'hda39a3ee},
		'{KEEP_MODE, ABC, 4'd3, 1'b1, 1'b1, 32'ha9993e36},
		'{KEEP_MODE, 64'hFFFFFFFFFFFFFFFF, 4'd9, 1'b1, 1'b0, 32'h0},
		'{3'(MODE_SHA384), 64'h0, 4'd0, 1'b1, 1'b1, 32'h38b060a7},
		'{KEEP_MODE, ABC, 4'd3, 1'b1, 1'b1, 32'hcb00753f},
		'{3'(MODE_SHA512), 64'h0, 4'd0, 1'b1, 1'b1, 32'hcf83e135},
		'{KEEP_MODE, ABC, 4'd3, 1'b1, 1'b1, 32'hddaf35a1},
		'{KEEP_MODE, 64'h5555AAAA5555AAAA, 4'd8, 1'b0, 1'b0, 32'h0},
		// mode write abandons the partial message
		'{3'(MODE_SHA512), 64'h0, 4'd0, 1'b1, 1'b1, 32'hcf83e135},
		'{3'(MODE_SHA256), 64'h1111111111111111, 4'd7, 1'b0, 1'b0, 32'h0},
		'{3'(MODE_SHA256), ABC, 4'd3, 1'b1, 1'b1, 32'hba7816bf}
	};

	// stimulus
	initial begin
		int items;
		int nwords;
		logic [3:0] nb;
		sha_mode = MODE_SHA256;
		restart_hash();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_tab[r]) begin
			if (stim_tab[r].mode != KEEP_MODE) write_mode(stim_tab[r].mode[1:0]);
			send_word(stim_tab[r].word, stim_tab[r].nbytes, stim_tab[r].last);
			if (stim_tab[r].known && first_digest !== stim_tab[r].first) begin
				$error("digest_word: expected %h, actual %h", stim_tab[r].first, first_digest);
				fail_count++;
			end
		end

		// random messages, mostly full words
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) write_mode(2'($urandom_range(0, 3)));
			quiet = items >= RANDOM_ITEMS - 30;
			nwords = $urandom_range(0, 7) == 0 ? $urandom_range(8, 20) : $urandom_range(0, 4);
			for (int i = 0; i <= nwords; i++) begin
				if (i == nwords)
					nb = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'd8;
				else if ($urandom_range(0, 4) == 0)
					nb = 4'($urandom_range(0, 15));
				else
					nb = 4'd8;
				send_word({$urandom, $urandom}, nb, i == nwords);
				if (nb != 0 || i == nwords) items++;
			end
		end
		in_valid <= 1'b0;

		wait (digest_q.size() == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("tb_multi_mode_sha_hash_engine: clean");
		else
			$display("tb_multi_mode_sha_hash_engine: errors");
		$finish;
	end

	// receiver stall bursts
	int stall_left = 0;
	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// digest transfer check
	always @(posedge clk) begin
		digest_xfer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("digest_word: unexpected transfer %h", digest_word);
				fail_count++;
			end else begin
				e = digest_q.pop_front();
				if (digest_word !== e.word) begin
					$error("digest_word: expected %h, actual %h", e.word, digest_word);
					fail_count++;
				end
				if (digest_last !== e.last) begin
					$error("digest_last: expected %b, actual %b", e.last, digest_last);
					fail_count++;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_multi_mode_sha_hash_engine: errors");
			$finish;
		end
	end

endmodule

`default_nettype wire
